// ===== design/aes_pkg.sv =====
// Shared constants and GF/S-box functions for the AES counter-mode cipher.
package aes_pkg;

    localparam int RoundKeyWords = 60;
    localparam logic [7:0] RconInit = 8'h01;
    localparam logic [7:0] XtimePoly = 8'h1b;

    localparam logic [1:0] MODE_AES128 = 2'd0;
    localparam logic [1:0] MODE_AES192 = 2'd1;
    localparam logic [1:0] MODE_AES256 = 2'd2;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_KEY0 = 3'd1;
    localparam logic [2:0] REG_KEY1 = 3'd2;
    localparam logic [2:0] REG_KEY2 = 3'd3;
    localparam logic [2:0] REG_KEY3 = 3'd4;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? XtimePoly : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// ===== design/aes_ctr_block_cipher.sv =====
// AES-CTR cipher: one item = up to 16 data bytes XOR AES of a little-endian counter block.
// Per round key: key fetch state (ST_KLOAD) and one round pass (ST_ROUND), then an output state
//   (ST_OUT); key expansion (ST_EXP) runs first after reset or a register write.
// The next item waits for the result to be delivered.
// A zero byte count returns its result in the cycle after accept.
// Reset: mode AES-256, key zero, counter 1, round keys marked invalid.
module aes_ctr_block_cipher #(
    parameter int ROUND_KEY_WORDS = aes_pkg::RoundKeyWords
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_lo,
    input  logic [63:0] s_data_hi,
    input  logic [4:0]  s_byte_count,
    input  logic        s_first_block,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_lo,
    output logic [63:0] m_result_hi,
    output logic [4:0]  m_result_count
);
    localparam int AW = $clog2(ROUND_KEY_WORDS);

    typedef enum logic [2:0] {ST_IDLE, ST_EXP, ST_KLOAD, ST_ROUND, ST_OUT} state_t;

    state_t       state_reg;
    logic [1:0]   mode_reg;
    logic [63:0]  key_reg [4];
    logic         keys_ready_reg;
    logic [63:0]  ctr_reg;
    logic [127:0] data_reg;
    logic [4:0]   cnt_reg;
    logic [127:0] st_reg;
    logic [3:0]   rnd_reg;
    logic [5:0]   wi_reg;
    logic [1:0]   kc_reg;
    logic [255:0] win_reg;   // last 8 expanded words, newest at top
    logic [7:0]   rc_reg;
    logic [2:0]   ph_reg;    // i mod Nk
    logic [31:0]  rk_mem [ROUND_KEY_WORDS];
    logic [127:0] rk_q_reg;
    logic [127:0] rk_buf_reg;
    logic         m_valid_reg;
    logic [63:0]  out_lo_reg, out_hi_reg;
    logic [4:0]   out_cnt_reg;

    logic [3:0] nk, nr;
    logic [5:0] total;
    always_comb begin
        case (mode_reg)
            aes_pkg::MODE_AES128: begin nk = 4'd4; nr = 4'd10; end
            aes_pkg::MODE_AES192: begin nk = 4'd6; nr = 4'd12; end
            default:              begin nk = 4'd8; nr = 4'd14; end
        endcase
        total = 6'(4 * (nk + 7));
    end

    // key expansion: one word per cycle
    logic [31:0] w_prev, w_nk, t_word, w_new;
    always_comb begin
        w_prev = win_reg[255:224];
        case (nk)
            4'd4:    w_nk = win_reg[159:128];
            4'd6:    w_nk = win_reg[95:64];
            default: w_nk = win_reg[31:0];
        endcase
        if (ph_reg == 3'd0)
            t_word = aes_pkg::sub_word({w_prev[7:0], w_prev[31:8]}) ^ {24'd0, rc_reg};
        else if (nk == 4'd8 && ph_reg == 3'd4)
            t_word = aes_pkg::sub_word(w_prev);
        else
            t_word = w_prev;
        w_new = w_nk ^ t_word;
    end

    logic [31:0] init_word;
    always_comb begin
        init_word = key_reg[wi_reg[2:1]][32*wi_reg[0] +: 32];
    end

    logic [127:0] round_out;
    aes_round_unit u_round (
        .state_in (st_reg),
        .round_key(rk_buf_reg),
        .mix_en   (rnd_reg != nr),
        .key_only (rnd_reg == 4'd0),
        .state_out(round_out)
    );

    // memory: one write port, one registered read port (word granularity, 4 reads per key)
    logic        mem_we;
    logic [5:0]  mem_wa;
    logic [31:0] mem_wd;
    logic [5:0]  mem_ra;
    logic [31:0] mem_rd_reg;
    always_ff @(posedge aclk) begin
        if (mem_we && mem_wa < 6'(ROUND_KEY_WORDS)) rk_mem[mem_wa[AW-1:0]] <= mem_wd;
        mem_rd_reg <= (mem_ra < 6'(ROUND_KEY_WORDS)) ? rk_mem[mem_ra[AW-1:0]] : 32'd0;
    end

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[5:3])
            aes_pkg::REG_MODE: prdata = {62'd0, mode_reg};
            aes_pkg::REG_KEY0: prdata = key_reg[0];
            aes_pkg::REG_KEY1: prdata = key_reg[1];
            aes_pkg::REG_KEY2: prdata = key_reg[2];
            aes_pkg::REG_KEY3: prdata = key_reg[3];
            default:           prdata = 64'd0;
        endcase
    end

    logic [4:0] cnt_in;
    assign cnt_in = (s_byte_count > 5'd16) ? 5'd16 : s_byte_count;
    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;

    // key fetch sequencing: kc_reg indexes the word within a round key, read address = rnd*4 + kc
    logic [5:0] fetch_addr;
    assign fetch_addr = 6'({rnd_reg, 2'b00}) + 6'(kc_reg);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = wi_reg;
        mem_wd = (wi_reg < 6'(nk)) ? init_word : w_new;
        mem_ra = fetch_addr;
        if (state_reg == ST_EXP) mem_we = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= aes_pkg::MODE_AES256;
            for (int i = 0; i < 4; i++) key_reg[i] <= 64'd0;
            keys_ready_reg <= 1'b0;
            ctr_reg        <= 64'd1;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[5:3])
                    aes_pkg::REG_MODE: begin mode_reg <= pwdata[1:0]; keys_ready_reg <= 1'b0; end
                    aes_pkg::REG_KEY0: begin key_reg[0] <= pwdata; keys_ready_reg <= 1'b0; end
                    aes_pkg::REG_KEY1: begin key_reg[1] <= pwdata; keys_ready_reg <= 1'b0; end
                    aes_pkg::REG_KEY2: begin key_reg[2] <= pwdata; keys_ready_reg <= 1'b0; end
                    aes_pkg::REG_KEY3: begin key_reg[3] <= pwdata; keys_ready_reg <= 1'b0; end
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        data_reg <= {s_data_hi, s_data_lo};
                        cnt_reg  <= cnt_in;
                        if (s_first_block) ctr_reg <= 64'd1;
                        if (cnt_in == 5'd0) begin
                            out_lo_reg  <= 64'd0;
                            out_hi_reg  <= 64'd0;
                            out_cnt_reg <= 5'd0;
                            m_valid_reg <= 1'b1;
                        end else begin
                            if (s_first_block) st_reg <= {64'd0, 64'd1};
                            else st_reg <= {64'd0, ctr_reg};
                            wi_reg  <= 6'd0;
                            ph_reg  <= 3'd0;
                            rc_reg  <= aes_pkg::RconInit;
                            rnd_reg <= 4'd0;
                            kc_reg  <= 2'd0;
                            state_reg <= keys_ready_reg ? ST_KLOAD : ST_EXP;
                        end
                    end
                end
                ST_EXP: begin
                    win_reg <= {mem_wd, win_reg[255:32]};
                    if (wi_reg >= 6'(nk)) begin
                        if (ph_reg == 3'd0) rc_reg <= aes_pkg::xtime(rc_reg);
                        ph_reg <= (ph_reg == 3'(nk - 4'd1)) ? 3'd0 : ph_reg + 3'd1;
                    end else if (wi_reg == 6'(nk) - 6'd1) begin
                        ph_reg <= 3'd0;
                    end
                    wi_reg <= wi_reg + 6'd1;
                    if (wi_reg == total - 6'd1) begin
                        keys_ready_reg <= 1'b1;
                        state_reg <= ST_KLOAD;
                    end
                end
                ST_KLOAD: begin
                    // issue 4 word reads, collect them from the registered read port
                    kc_reg <= kc_reg + 2'd1;
                    rk_q_reg <= {mem_rd_reg, rk_q_reg[127:32]};
                    if (wi_reg == 6'd63) begin
                        rk_buf_reg <= {mem_rd_reg, rk_q_reg[127:32]};
                        wi_reg <= 6'd0;
                        state_reg <= ST_ROUND;
                    end else if (kc_reg == 2'd3) begin
                        wi_reg <= 6'd63;
                    end
                end
                ST_ROUND: begin
                    st_reg  <= round_out;
                    kc_reg  <= 2'd0;
                    if (rnd_reg == nr) begin
                        for (int i = 0; i < 16; i++) begin
                            if (5'(i) < cnt_reg) begin
                                if (i < 8) out_lo_reg[8*i +: 8] <= data_reg[8*i +: 8] ^ round_out[8*i +: 8];
                                else out_hi_reg[8*(i-8) +: 8] <= data_reg[8*i +: 8] ^ round_out[8*i +: 8];
                            end else begin
                                if (i < 8) out_lo_reg[8*i +: 8] <= 8'd0;
                                else out_hi_reg[8*(i-8) +: 8] <= 8'd0;
                            end
                        end
                        out_cnt_reg <= cnt_reg;
                        ctr_reg     <= ctr_reg + 64'd1;
                        state_reg   <= ST_OUT;
                    end else begin
                        rnd_reg   <= rnd_reg + 4'd1;
                        state_reg <= ST_KLOAD;
                    end
                end
                ST_OUT: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_lo    = out_lo_reg;
    assign m_result_hi    = out_hi_reg;
    assign m_result_count = out_cnt_reg;

    a_out_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_result_count <= 5'd16)
        else $error("result count above 16");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("ready while busy");
    a_round_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> rnd_reg <= nr)
        else $error("round index past last round");
endmodule

// ===== design/aes_round_unit.sv =====
// Shared AES round datapath: SubBytes, ShiftRows, optional MixColumns, AddRoundKey (key_only: AddRoundKey alone).
module aes_round_unit (
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    input  logic         mix_en,
    input  logic         key_only,
    output logic [127:0] state_out
);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [127:0] r;

    always_comb begin
        for (int i = 0; i < 16; i++) s[i] = state_in[8*i +: 8];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) t[c*4+k] = aes_pkg::SBOX[s[((c+k)%4)*4+k]];
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] all;
            all = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
            m[c*4+0] = mix_en ? t[c*4+0] ^ all ^ aes_pkg::xtime(t[c*4+0] ^ t[c*4+1]) : t[c*4+0];
            m[c*4+1] = mix_en ? t[c*4+1] ^ all ^ aes_pkg::xtime(t[c*4+1] ^ t[c*4+2]) : t[c*4+1];
            m[c*4+2] = mix_en ? t[c*4+2] ^ all ^ aes_pkg::xtime(t[c*4+2] ^ t[c*4+3]) : t[c*4+2];
            m[c*4+3] = mix_en ? t[c*4+3] ^ all ^ aes_pkg::xtime(t[c*4+3] ^ t[c*4+0]) : t[c*4+3];
        end
        for (int i = 0; i < 16; i++) r[8*i +: 8] = m[i];
        state_out = (key_only ? state_in : r) ^ round_key;
    end
endmodule

// ===== tb/aes_ctr_block_cipher_tb.sv =====
// Testbench for the AES-CTR block cipher: directed and random items checked against a behavioral AES model.
module aes_ctr_block_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] data_lo;
        logic [63:0] data_hi;
        logic [4:0]  byte_count;
        logic        first_block;
    } cipher_item_t;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  count;
    } cipher_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_data_lo = '0, s_data_hi = '0;
    logic [4:0]  s_byte_count = '0;
    logic        s_first_block = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_result_lo, m_result_hi;
    logic [4:0]  m_result_count;

    aes_ctr_block_cipher uut (.*);

    always #10 aclk = ~aclk;

    // model state
    logic [1:0]  mdl_mode;
    logic [63:0] mdl_key [4];
    logic [31:0] mdl_rk [60];
    logic [63:0] mdl_ctr;
    bit          mdl_keys_ok;

    cipher_item_t pending_items[$];
    cipher_out_t  expected_out[$];
    int errors = 0;
    int mismatches = 0;
    bit idle_off = 1'b0;
    bit hold_off = 1'b0;
    int stall_cycles = 0;

    function automatic int nk_of(logic [1:0] m);
        return m == aes_pkg::MODE_AES128 ? 4 : (m == aes_pkg::MODE_AES192 ? 6 : 8);
    endfunction

    function automatic logic [7:0] gmul2(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] subw(logic [31:0] w);
        return {aes_pkg::SBOX[w[31:24]], aes_pkg::SBOX[w[23:16]],
                aes_pkg::SBOX[w[15:8]], aes_pkg::SBOX[w[7:0]]};
    endfunction

    task automatic expand_round_keys();
        int nk, total;
        logic [7:0] rc;
        logic [31:0] t;
        logic [31:0] w [60];
        nk = nk_of(mdl_mode);
        total = 4 * (nk + 7);
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            w[i] = mdl_key[(4 * i) >> 3][((4 * i) % 8) * 8 +: 32];
        for (int i = nk; i < total; i++) begin
            t = w[i - 1];
            if (i % nk == 0) begin
                t = subw({t[7:0], t[31:8]}) ^ {24'h0, rc};
                rc = gmul2(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = subw(t);
            end
            w[i] = w[i - nk] ^ t;
        end
        for (int i = 0; i < 60; i++) mdl_rk[i] = i < total ? w[i] : 32'h0;
        mdl_keys_ok = 1'b1;
    endtask

    task automatic add_rk(inout logic [7:0] s [16], input int rnd);
        logic [31:0] k;
        for (int c = 0; c < 4; c++) begin
            k = mdl_rk[rnd * 4 + c];
            for (int b = 0; b < 4; b++) s[c * 4 + b] ^= k[8 * b +: 8];
        end
    endtask

    task automatic aes_rnd(inout logic [7:0] s [16], input bit mix);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[c * 4 + r] = aes_pkg::SBOX[s[((c + r) % 4) * 4 + r]];
        if (mix)
            for (int c = 0; c < 4; c++) begin
                a0 = t[c * 4]; a1 = t[c * 4 + 1]; a2 = t[c * 4 + 2]; a3 = t[c * 4 + 3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[c * 4]     = a0 ^ al ^ gmul2(a0 ^ a1);
                t[c * 4 + 1] = a1 ^ al ^ gmul2(a1 ^ a2);
                t[c * 4 + 2] = a2 ^ al ^ gmul2(a2 ^ a3);
                t[c * 4 + 3] = a3 ^ al ^ gmul2(a3 ^ a0);
            end
        s = t;
    endtask

    task automatic predict_cipher(input cipher_item_t it);
        logic [7:0] s [16];
        cipher_out_t o;
        int cnt, rounds;
        cnt = it.byte_count > 16 ? 16 : it.byte_count;
        o = '0;
        o.count = cnt[4:0];
        if (it.first_block) mdl_ctr = 64'd1;
        if (cnt != 0) begin
            if (!mdl_keys_ok) expand_round_keys();
            rounds = nk_of(mdl_mode) + 6;
            for (int i = 0; i < 8; i++) begin
                s[i] = mdl_ctr[8 * i +: 8];
                s[i + 8] = 8'h00;
            end
            add_rk(s, 0);
            for (int r = 1; r < rounds; r++) begin
                aes_rnd(s, 1'b1);
                add_rk(s, r);
            end
            aes_rnd(s, 1'b0);
            add_rk(s, rounds);
            for (int i = 0; i < cnt; i++)
                if (i < 8) o.lo[8 * i +: 8] = it.data_lo[8 * i +: 8] ^ s[i];
                else o.hi[8 * (i - 8) +: 8] = it.data_hi[8 * (i - 8) +: 8] ^ s[i];
            mdl_ctr = mdl_ctr + 64'd1;
        end
        expected_out.push_back(o);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        // an index beyond the register list changes nothing
        if (idx == aes_pkg::REG_MODE) begin
            mdl_mode = val[1:0];
            mdl_keys_ok = 1'b0;
        end else if (idx <= aes_pkg::REG_KEY3) begin
            mdl_key[idx - 1] = val;
            mdl_keys_ok = 1'b0;
        end
    endtask

    function automatic cipher_item_t rand_item(bit zero_ok);
        cipher_item_t it;
        it.data_lo = {$urandom, $urandom};
        it.data_hi = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: it.byte_count = zero_ok ? 5'd0 : 5'd16;
            1: it.byte_count = 5'($urandom_range(17, 31));
            2, 3: it.byte_count = 5'($urandom_range(1, 15));
            default: it.byte_count = 5'd16;
        endcase
        it.first_block = $urandom_range(0, 7) == 0;
        return it;
    endfunction

    // queue items, predicting at push time (model order equals acceptance order)
    task automatic offer(input cipher_item_t it);
        pending_items.push_back(it);
        predict_cipher(it);
    endtask

    task automatic wait_drain();
        while (pending_items.size() != 0 || s_valid || expected_out.size() != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() != 0 && (idle_off || $urandom_range(0, 99) >= 28)) begin
                cipher_item_t it;
                it = pending_items.pop_front();
                s_valid <= 1'b1;
                s_data_lo <= it.data_lo;
                s_data_hi <= it.data_hi;
                s_byte_count <= it.byte_count;
                s_first_block <= it.first_block;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver ready, with a long hold-off when requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off && stall_cycles < 400) begin
            stall_cycles <= stall_cycles + 1;
            m_ready <= 1'b0;
        end else begin
            if (!hold_off) stall_cycles <= 0;
            m_ready <= idle_off || ($urandom_range(0, 99) >= 28);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_out.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result item %h", m_result_lo);
            end else begin
                cipher_out_t e;
                e = expected_out.pop_front();
                if (m_result_lo !== e.lo || m_result_hi !== e.hi ||
                    m_result_count !== e.count) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: exp %h %h %0d got %h %h %0d", e.lo, e.hi,
                                 e.count, m_result_lo, m_result_hi, m_result_count);
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("aes_ctr_block_cipher test failed");
        $finish;
    end

    initial begin
        cipher_item_t it;
        mdl_mode = aes_pkg::MODE_AES256;
        for (int i = 0; i < 4; i++) mdl_key[i] = '0;
        mdl_ctr = 64'd1;
        mdl_keys_ok = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset key, extremes, zero count, oversize count, restart
        it = '{64'h0, 64'h0, 5'd16, 1'b0}; offer(it);
        it = '{'1, '1, 5'd16, 1'b0}; offer(it);
        it = '{'1, '1, 5'd0, 1'b0}; offer(it);
        it = '{'1, '1, 5'd0, 1'b1}; offer(it);
        it = '{'1, '1, 5'd1, 1'b0}; offer(it);
        it = '{'1, '1, 5'd31, 1'b0}; offer(it);
        it = '{64'h0123456789abcdef, '1, 5'd8, 1'b1}; offer(it);
        it = '{'1, '1, 5'd9, 1'b0}; offer(it);
        it = '{'1, '1, 5'd17, 1'b0}; offer(it);
        wait_drain();

        // FIPS-197 style keys per mode, mode three, a write to an unused register, then random keys
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    reg_write(aes_pkg::REG_MODE, 64'(aes_pkg::MODE_AES128));
                    reg_write(aes_pkg::REG_KEY0, 64'h0706050403020100);
                    reg_write(aes_pkg::REG_KEY1, 64'h0f0e0d0c0b0a0908);
                end
                1: begin
                    reg_write(aes_pkg::REG_MODE, 64'(aes_pkg::MODE_AES192));
                    reg_write(aes_pkg::REG_KEY2, 64'h1716151413121110);
                end
                2: begin
                    reg_write(aes_pkg::REG_MODE, 64'(aes_pkg::MODE_AES256));
                    reg_write(aes_pkg::REG_KEY3, 64'h1f1e1d1c1b1a1918);
                end
                3: begin
                    reg_write(aes_pkg::REG_MODE, 64'd3);
                    for (int k = 1; k <= 4; k++) reg_write(3'(k), '1);
                end
                4: reg_write(3'd5, {$urandom, $urandom});
                default: begin
                    reg_write(aes_pkg::REG_MODE, 64'($urandom_range(0, 3)));
                    for (int k = 1; k <= 4; k++) reg_write(3'(k), {$urandom, $urandom});
                end
            endcase
            if (ph == 4) begin
                idle_off = 1'b1;
                hold_off = 1'b1;
            end
            for (int n = 0; n < 235; n++) offer(rand_item(1'b1));
            while (hold_off && stall_cycles < 400) @(posedge aclk);
            hold_off = 1'b0;
            // long stretch with both sides always active
            if (idle_off) begin
                repeat (4000) @(posedge aclk);
                idle_off = 1'b0;
            end
            wait_drain();
        end

        if (errors == 0) begin
            $display("aes_ctr_block_cipher test passed");
        end else begin
            $display("aes_ctr_block_cipher test failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
design/aes_pkg.sv
design/aes_round_unit.sv
design/aes_ctr_block_cipher.sv
tb/aes_ctr_block_cipher_tb.sv
